[design/tmsf_pkg.sv]
// Shared constants and types for the trimmed median smoothing filter.
`default_nettype none

package tmsf_pkg;

  localparam int WINDOW_LEN   = 9;
  localparam int SAMPLE_BITS  = 12;
  localparam int FRAC_BITS    = 8;
  localparam int SMOOTH_DIV   = 10;
  localparam int SMOOTH_KEEP  = SMOOTH_DIV - 1;
  localparam int CENTRE_COUNT = 3;

  localparam int AGE_W  = $clog2(WINDOW_LEN);
  localparam int MID    = WINDOW_LEN / 2;
  localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int NUM_W  = ACC_W + 4;

  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ACC_W + SAMPLE_BITS + 7) / 8) * 8;

  // reciprocals, floor(2^k / d); the quotient is at most one short
  localparam logic [SUM_W-1:0] RECIP3  = SUM_W'((2 ** SUM_W) / CENTRE_COUNT);
  localparam logic [NUM_W-1:0] RECIP10 = NUM_W'((2 ** NUM_W) / SMOOTH_DIV);

  // one sorted window entry as seen by its neighbors
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;
    logic [AGE_W-1:0]       age;
    logic                   le;   // val <= incoming sample
  } tmsf_link_t;

  // sentinels beyond both ends of the row
  localparam tmsf_link_t LINK_FLOOR = '{val: '0, age: '0, le: 1'b1};
  localparam tmsf_link_t LINK_CEIL  = '{val: '0, age: '0, le: 1'b0};

endpackage

`default_nettype wire

[design/tmsf_cell.sv]
// One cell of the sorted window row: deletes the oldest entry, inserts the new sample.
`default_nettype none

module tmsf_cell (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 en,
  input  wire  [tmsf_pkg::SAMPLE_BITS-1:0]    x,
  input  wire  [tmsf_pkg::AGE_W-1:0]          init_age,
  input  tmsf_pkg::tmsf_link_t                lft,
  input  tmsf_pkg::tmsf_link_t                rgt,
  input  wire                                 del_in,   // oldest entry lies left of here
  output tmsf_pkg::tmsf_link_t                own,
  output logic                                del_out
);

  logic [tmsf_pkg::SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [tmsf_pkg::AGE_W-1:0]       age_r, age_nxt;
  logic                             is_del;

  assign is_del  = (age_r == tmsf_pkg::AGE_W'(tmsf_pkg::WINDOW_LEN - 1));
  assign del_out = del_in | is_del;

  assign own.val = val_r;
  assign own.age = age_r;
  assign own.le  = (val_r <= x);

  always_comb begin
    val_nxt = x;
    age_nxt = '0;
    if (!del_in && !is_del) begin
      // oldest entry is to the right: shift up only past the insert point
      if (own.le) begin
        val_nxt = val_r;
        age_nxt = age_r + 1'b1;
      end else if (!lft.le) begin
        val_nxt = lft.val;
        age_nxt = lft.age + 1'b1;
      end
    end else begin
      // oldest entry is here or to the left: entries close the gap downward
      if (rgt.le) begin
        val_nxt = rgt.val;
        age_nxt = rgt.age + 1'b1;
      end else if (del_in && !own.le) begin
        val_nxt = val_r;
        age_nxt = age_r + 1'b1;
      end else if (is_del && !lft.le) begin
        val_nxt = lft.val;
        age_nxt = lft.age + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= init_age;
    end else if (en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tmsf_smoother.sv]
// Exponential smoother: acc = (acc * 9 + mean * 256) / 10, truncated.
`default_nettype none

module tmsf_smoother (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               en,
  input  wire  [tmsf_pkg::SAMPLE_BITS-1:0]  mean,
  output logic [tmsf_pkg::ACC_W-1:0]        acc
);

  localparam int NW = tmsf_pkg::NUM_W;

  logic [tmsf_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [NW-1:0]              num;
  logic [2*NW-1:0]            prod;
  logic [NW-1:0]              q0;
  logic [NW-1:0]              rem;

  assign num  = NW'(acc_r) * NW'(tmsf_pkg::SMOOTH_KEEP)
              + (NW'(mean) << tmsf_pkg::FRAC_BITS);
  assign prod = (2 * NW)'(num) * (2 * NW)'(tmsf_pkg::RECIP10);
  assign q0   = prod[2*NW-1:NW];
  assign rem  = num - q0 * NW'(tmsf_pkg::SMOOTH_DIV);

  always_comb begin
    if (rem >= NW'(tmsf_pkg::SMOOTH_DIV)) begin
      acc_nxt = tmsf_pkg::ACC_W'(q0 + 1'b1);
    end else begin
      acc_nxt = tmsf_pkg::ACC_W'(q0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

[design/trimmed_median_smoothing_filter.sv]
// Top level: sorted window cell row, centre mean, exponential smoother.
//
//  channel | dir | fields (low bit first)                      | handshake
//  in_     | in  | sample[11:0], zero pad to 16                | in_tvalid/in_tready
//  out_    | out | smoothed[19:0], trimmed_mean[31:20]          | out_tvalid/out_tready
//
// One item per cycle sustained while out_tready stays high. Three register stages: cell
// row update, centre mean (/3 by reciprocal), smoother plus output register. After the
// accepting edge an item passes the mean register, then raises out_tvalid.
// The rate is set by the cell row, which inserts the new sample and drops the
// oldest one in the same cycle, and by the smoother's registered feedback loop.
// Synchronous active-low reset zeros the window and the smoother.
// Stalls back up stage by stage; input is still taken while bubbles remain.
`default_nettype none

module trimmed_median_smoothing_filter (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [tmsf_pkg::IN_TDATA_W-1:0]      in_tdata,   // sample[11:0], pad
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [tmsf_pkg::OUT_TDATA_W-1:0]     out_tdata   // smoothed[19:0], trimmed_mean[31:20]
);

  localparam int N  = tmsf_pkg::WINDOW_LEN;
  localparam int SB = tmsf_pkg::SAMPLE_BITS;
  localparam int SW = tmsf_pkg::SUM_W;

  // pipeline handshake
  logic in_acc;
  logic rdy_a, rdy_b, rdy_c;
  logic va_r, va_nxt;
  logic vb_r, vb_nxt;
  logic out_valid_r, out_valid_nxt;

  assign rdy_c     = !out_valid_r || out_tready;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign in_tready = rdy_a;
  assign in_acc    = in_tvalid && rdy_a;

  // sorted window: a row of cells, lowest value in cell 0
  logic [SB-1:0]            sample;
  tmsf_pkg::tmsf_link_t     lnk [N];
  logic [N:0]               del_c;
  logic [N-1:0]             is_del;

  assign sample   = in_tdata[SB-1:0];
  assign del_c[0] = 1'b0;

  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    tmsf_pkg::tmsf_link_t lft, rgt;

    if (gi == 0) begin : g_lo
      assign lft = tmsf_pkg::LINK_FLOOR;
    end else begin : g_lo_n
      assign lft = lnk[gi-1];
    end
    if (gi == N - 1) begin : g_hi
      assign rgt = tmsf_pkg::LINK_CEIL;
    end else begin : g_hi_n
      assign rgt = lnk[gi+1];
    end

    tmsf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (in_acc),
      .x        (sample),
      .init_age (tmsf_pkg::AGE_W'(gi)),
      .lft      (lft),
      .rgt      (rgt),
      .del_in   (del_c[gi]),
      .own      (lnk[gi]),
      .del_out  (del_c[gi+1])
    );

    assign is_del[gi] = (lnk[gi].age == tmsf_pkg::AGE_W'(N - 1));
  end

  // centre mean: floor(sum / 3) by reciprocal and one correction
  logic [SW-1:0]   csum;
  logic [2*SW-1:0] cprod;
  logic [SW-1:0]   cq0;
  logic [SW-1:0]   crem;
  logic [SB-1:0]   mean_c;
  logic [SB-1:0]   mean_r, mean_nxt;
  logic [SB-1:0]   mean_o_r, mean_o_nxt;

  assign csum  = SW'(lnk[tmsf_pkg::MID-1].val) + SW'(lnk[tmsf_pkg::MID].val)
               + SW'(lnk[tmsf_pkg::MID+1].val);
  assign cprod = (2 * SW)'(csum) * (2 * SW)'(tmsf_pkg::RECIP3);
  assign cq0   = cprod[2*SW-1:SW];
  assign crem  = csum - cq0 * SW'(tmsf_pkg::CENTRE_COUNT);

  always_comb begin
    if (crem >= SW'(tmsf_pkg::CENTRE_COUNT)) begin
      mean_c = SB'(cq0 + 1'b1);
    end else begin
      mean_c = SB'(cq0);
    end
  end

  // smoother; its register doubles as the smoothed output field
  logic [tmsf_pkg::ACC_W-1:0] acc;

  tmsf_smoother u_smooth (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (rdy_c && vb_r),
    .mean  (mean_r),
    .acc   (acc)
  );

  always_comb begin
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    out_valid_nxt = out_valid_r;
    mean_nxt      = mean_r;
    mean_o_nxt    = mean_o_r;
    if (rdy_a) begin
      va_nxt = in_tvalid;
    end
    if (rdy_b) begin
      vb_nxt   = va_r;
      mean_nxt = mean_c;
    end
    if (rdy_c) begin
      out_valid_nxt = vb_r;
      mean_o_nxt    = mean_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mean_r   <= mean_nxt;
    mean_o_r <= mean_o_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tmsf_pkg::OUT_TDATA_W'({mean_o_r, acc});

`ifndef ASSERT_OFF
  // exactly one cell holds the oldest sample
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(is_del))
    else $error("cell row: oldest-entry mark not unique");

  // the row stays sorted ascending
  for (genvar ai = 0; ai < N - 1; ai++) begin : g_ord
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      lnk[ai].val <= lnk[ai+1].val)
      else $error("cell row: entries out of order");
  end

  // smoother never exceeds the largest sample in 12.8
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc <= (tmsf_pkg::ACC_W'((2 ** SB) - 1) << tmsf_pkg::FRAC_BITS))
    else $error("smoother out of range");
`endif

endmodule

`default_nettype wire
